// ===== rtl/utf8d_pkg.sv =====
// Shared types and constants for the UTF-8 decoder with replacement.
package utf8d_pkg;

   localparam int DEFAULT_QUEUE_DEPTH = 4;

   localparam int CP_W    = 21;
   localparam int COUNT_W = 3;

   localparam logic [2:0] SEQ_NONE  = 3'd0;
   localparam logic [2:0] SEQ_TWO   = 3'd2;
   localparam logic [2:0] SEQ_THREE = 3'd3;
   localparam logic [2:0] SEQ_FOUR  = 3'd4;

   localparam logic [CP_W-1:0] REPLACEMENT_CP = 21'h00FFFD;
   localparam logic [CP_W-1:0] MAX_SCALAR     = 21'h10FFFF;
   localparam logic [CP_W-1:0] SURR_LOW       = 21'h00D800;
   localparam logic [CP_W-1:0] SURR_HIGH      = 21'h00DFFF;
   localparam logic [CP_W-1:0] MIN_TWO        = 21'h000080;
   localparam logic [CP_W-1:0] MIN_THREE      = 21'h000800;
   localparam logic [CP_W-1:0] MIN_FOUR       = 21'h010000;

   typedef struct packed {
      logic [COUNT_W-1:0] repl_count;
      logic               has_cp;
      logic [CP_W-1:0]    cp;
      logic               text_end;
   } queue_entry_type;

endpackage

// ===== rtl/utf8d_front.sv =====
// Front stage: accepts bytes, tracks the open sequence and queues result runs.
module utf8d_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [7:0]                 req_text_byte,
   input  logic                       req_end_of_text,
   input  logic                       queue_full,
   output logic                       queue_push,
   output utf8d_pkg::queue_entry_type queue_entry
);
   import utf8d_pkg::*;

   logic [CP_W-1:0]    partial_ff, partial_in;
   logic [2:0]         seq_len_ff, seq_len_in;
   logic [1:0]         gathered_ff, gathered_in;

   logic               accept;
   logic               in_seq;
   logic               is_cont;
   logic [2:0]         gathered_next;
   logic [CP_W-1:0]    value_next;
   logic [CP_W-1:0]    min_value;
   logic               value_bad;
   logic [COUNT_W-1:0] base_count;
   logic [COUNT_W-1:0] repl_count;
   logic               has_cp;
   logic [CP_W-1:0]    cp;
   logic               opens_seq;

   assign req_stall     = queue_full;
   assign accept        = req_valid && !queue_full;
   assign in_seq        = seq_len_ff != SEQ_NONE;
   assign is_cont       = req_text_byte[7:6] == 2'b10;
   assign gathered_next = {1'b0, gathered_ff} + 3'd1;
   assign value_next    = {partial_ff[14:0], req_text_byte[5:0]};
   assign base_count    = in_seq ? {1'b0, gathered_ff} : '0;

   always_comb begin
      unique case (seq_len_ff)
         SEQ_TWO:   min_value = MIN_TWO;
         SEQ_THREE: min_value = MIN_THREE;
         default:   min_value = MIN_FOUR;
      endcase
   end

   assign value_bad = (value_next < min_value) || (value_next > MAX_SCALAR) ||
                      ((value_next >= SURR_LOW) && (value_next <= SURR_HIGH));

   always_comb begin
      partial_in  = '0;
      seq_len_in  = SEQ_NONE;
      gathered_in = '0;
      repl_count  = '0;
      has_cp      = 1'b0;
      cp          = value_next;
      opens_seq   = 1'b0;
      if (in_seq && is_cont) begin
         if (gathered_next >= seq_len_ff) begin
            if (value_bad) begin
               repl_count = seq_len_ff;
            end else begin
               has_cp = 1'b1;
            end
         end else if (req_end_of_text) begin
            repl_count = gathered_next;
         end else begin
            partial_in  = value_next;
            seq_len_in  = seq_len_ff;
            gathered_in = gathered_next[1:0];
         end
      end else begin
         repl_count = base_count;
         if (!req_text_byte[7]) begin
            has_cp = 1'b1;
            cp     = {13'd0, req_text_byte};
         end else if (req_text_byte[7:5] == 3'b110) begin
            opens_seq  = 1'b1;
            partial_in = {16'd0, req_text_byte[4:0]};
            seq_len_in = SEQ_TWO;
         end else if (req_text_byte[7:4] == 4'b1110) begin
            opens_seq  = 1'b1;
            partial_in = {17'd0, req_text_byte[3:0]};
            seq_len_in = SEQ_THREE;
         end else if (req_text_byte[7:3] == 5'b11110) begin
            opens_seq  = 1'b1;
            partial_in = {18'd0, req_text_byte[2:0]};
            seq_len_in = SEQ_FOUR;
         end else begin
            repl_count = base_count + 3'd1;
         end
         if (opens_seq) begin
            if (req_end_of_text) begin
               repl_count = base_count + 3'd1;
               partial_in = '0;
               seq_len_in = SEQ_NONE;
            end else begin
               gathered_in = 2'd1;
            end
         end
      end
   end

   assign queue_push             = accept && ((repl_count != '0) || has_cp);
   assign queue_entry.repl_count = repl_count;
   assign queue_entry.has_cp     = has_cp;
   assign queue_entry.cp         = cp;
   assign queue_entry.text_end   = req_end_of_text;

   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff  <= '0;
         seq_len_ff  <= SEQ_NONE;
         gathered_ff <= '0;
      end else if (accept) begin
         partial_ff  <= partial_in;
         seq_len_ff  <= seq_len_in;
         gathered_ff <= gathered_in;
      end
   end

endmodule

// ===== rtl/utf8d_queue.sv =====
// Short queue of result runs between the front and back stages.
module utf8d_queue #(
   parameter int DEPTH = utf8d_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  utf8d_pkg::queue_entry_type push_entry,
   input  logic                       pop,
   output utf8d_pkg::queue_entry_type head_entry,
   output logic                       full,
   output logic                       empty
);
   import utf8d_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   queue_entry_type   entries_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign full       = count_ff == CNT_W'(DEPTH);
   assign empty      = count_ff == '0;
   assign do_push    = push && !full;
   assign do_pop     = pop && !empty;
   assign head_entry = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== rtl/utf8d_back.sv =====
// Back stage: expands each queued run into result items on the output register.
module utf8d_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       queue_empty,
   input  utf8d_pkg::queue_entry_type head_entry,
   output logic                       queue_pop,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [20:0]                rsp_code_point,
   output logic                       rsp_is_replacement,
   output logic                       rsp_last_of_run,
   output logic                       rsp_text_done
);
   import utf8d_pkg::*;

   logic               valid_ff, valid_in;
   logic [CP_W-1:0]    cp_ff;
   logic               repl_ff;
   logic               last_ff;
   logic               done_ff;
   logic [1:0]         idx_ff, idx_in;

   logic               load;
   logic [COUNT_W-1:0] total;
   logic               repl_slot;
   logic               last_slot;

   assign load      = !queue_empty && (!valid_ff || !rsp_stall);
   assign total     = head_entry.repl_count + {2'd0, head_entry.has_cp};
   assign repl_slot = {1'b0, idx_ff} < head_entry.repl_count;
   assign last_slot = ({1'b0, idx_ff} + 3'd1) == total;
   assign queue_pop = load && last_slot;

   always_comb begin
      valid_in = valid_ff && rsp_stall;
      idx_in   = idx_ff;
      if (load) begin
         valid_in = 1'b1;
         idx_in   = last_slot ? 2'd0 : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         cp_ff   <= repl_slot ? REPLACEMENT_CP : head_entry.cp;
         repl_ff <= repl_slot;
         last_ff <= last_slot;
         done_ff <= last_slot && head_entry.text_end;
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_code_point     = cp_ff;
   assign rsp_is_replacement = repl_ff;
   assign rsp_last_of_run    = last_ff;
   assign rsp_text_done      = done_ff;

endmodule

// ===== rtl/utf8_decoder_with_replacement.sv =====
// Top level of the UTF-8 decoder with replacement.
//
// req_ channel: one raw byte per item, req_end_of_text set on the last byte of
// a text. rsp_ channel: one code point per item, U+FFFD with
// rsp_is_replacement for every rejected byte, rsp_last_of_run on the final
// item caused by a byte, rsp_text_done on the final item of the text.
// A byte is taken when req_valid is high and req_stall low; an item leaves
// when rsp_valid is high and rsp_stall low.
// The first item of a byte passes through the run queue and then the output
// register. Intermediate bytes of a sequence give no item.
// Throughput: one byte per cycle while the queue is not full and each byte
// gives at most one item; the output register issues one item per cycle
// while rsp_stall is low, so a run of up to four replacements occupies it
// until its last item has left. The run queue between the decode front and
// the output stage absorbs such bursts; req_stall rises only when it is full.
// Reset: clears the open sequence, the queue and the output register.
// While rsp_stall is high the output item holds and the queue fills behind it.
module utf8_decoder_with_replacement #(
   parameter int QUEUE_DEPTH = utf8d_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_text_byte,
   input  logic        req_end_of_text,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [20:0] rsp_code_point,
   output logic        rsp_is_replacement,
   output logic        rsp_last_of_run,
   output logic        rsp_text_done
);
   import utf8d_pkg::*;

   queue_entry_type push_entry;
   queue_entry_type head_entry;
   logic            push;
   logic            pop;
   logic            full;
   logic            empty;

   utf8d_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_text_byte   (req_text_byte),
      .req_end_of_text (req_end_of_text),
      .queue_full      (full),
      .queue_push      (push),
      .queue_entry     (push_entry)
   );

   utf8d_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .full       (full),
      .empty      (empty)
   );

   utf8d_back u_back (
      .clock              (clock),
      .reset              (reset),
      .queue_empty        (empty),
      .head_entry         (head_entry),
      .queue_pop          (pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_code_point     (rsp_code_point),
      .rsp_is_replacement (rsp_is_replacement),
      .rsp_last_of_run    (rsp_last_of_run),
      .rsp_text_done      (rsp_text_done)
   );

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for the UTF-8 decoder with replacement.
`timescale 1ns / 1ps

module tb_top;
   import utf8d_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_BYTES = 320;
   localparam int DRAIN_CYCLES = 20;
   localparam int IDLE_PCT     = 21;
   localparam int BYTE_CAP     = RANDOM_BYTES + 4;
   localparam int PEND_CAP     = 2048;

   typedef struct packed {
      logic [CP_W-1:0] cp;
      logic            repl;
      logic            last;
      logic            done;
   } cp_item_type;

   typedef struct packed {
      logic [7:0]      text_byte;
      logic            eot;
      logic            typed;
      logic [CP_W-1:0] cp;
      logic            repl;
   } text_row_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_text_byte;
   logic        req_end_of_text;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [20:0] rsp_code_point;
   logic        rsp_is_replacement;
   logic        rsp_last_of_run;
   logic        rsp_text_done;

   utf8_decoder_with_replacement dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_text_byte      (req_text_byte),
      .req_end_of_text    (req_end_of_text),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_code_point     (rsp_code_point),
      .rsp_is_replacement (rsp_is_replacement),
      .rsp_last_of_run    (rsp_last_of_run),
      .rsp_text_done      (rsp_text_done)
   );

   text_row_type text_rows [25] = '{
      '{8'h00, 1'b0, 1'b1, 21'h000000, 1'b0},
      '{8'h7F, 1'b0, 1'b1, 21'h00007F, 1'b0},
      '{8'h80, 1'b0, 1'b1, REPLACEMENT_CP, 1'b1},
      '{8'hFF, 1'b0, 1'b1, REPLACEMENT_CP, 1'b1},
      '{8'hF8, 1'b0, 1'b1, REPLACEMENT_CP, 1'b1},
      '{8'hC0, 1'b0, 1'b0, 21'h0, 1'b0},
      '{8'h80, 1'b0, 1'b0, 21'h0, 1'b0},
      '{8'hED, 1'b0, 1'b0, 21'h0, 1'b0},
      '{8'hA0, 1'b0, 1'b0, 21'h0, 1'b0},
      '{8'h80, 1'b0, 1'b0, 21'h0, 1'b0},
      '{8'hF4, 1'b0, 1'b0, 21'h0, 1'b0},
      '{8'h8F, 1'b0, 1'b0, 21'h0, 1'b0},
      '{8'hBF, 1'b0, 1'b0, 21'h0, 1'b0},
      '{8'hBF, 1'b0, 1'b0, 21'h0, 1'b0},
      '{8'hF4, 1'b0, 1'b0, 21'h0, 1'b0},
      '{8'h90, 1'b0, 1'b0, 21'h0, 1'b0},
      '{8'h80, 1'b0, 1'b0, 21'h0, 1'b0},
      '{8'h80, 1'b0, 1'b0, 21'h0, 1'b0},
      '{8'hE2, 1'b0, 1'b0, 21'h0, 1'b0},
      '{8'h41, 1'b0, 1'b0, 21'h0, 1'b0},
      '{8'hF0, 1'b0, 1'b0, 21'h0, 1'b0},
      '{8'h90, 1'b0, 1'b0, 21'h0, 1'b0},
      '{8'hC3, 1'b0, 1'b0, 21'h0, 1'b0},
      '{8'hA9, 1'b1, 1'b0, 21'h0, 1'b0},
      '{8'hE2, 1'b1, 1'b0, 21'h0, 1'b0}
   };

   cp_item_type pending_cps [PEND_CAP];
   int          pend_wr;
   int          pend_rd;
   cp_item_type decoded_cps [4];
   int          decoded_count;
   logic [7:0]  text_bytes  [BYTE_CAP];
   logic        text_ends   [BYTE_CAP];
   int          text_count;

   logic [CP_W-1:0] scalar_acc;
   logic [2:0]      seq_len;
   logic [1:0]      seq_taken;

   bit calm;
   int error_count;
   int cycle_count;
   int cps_checked;
   int repl_checked;
   int texts_closed;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_top: errors");
         $finish;
      end
   end

   function automatic void put_cp(logic [CP_W-1:0] cp, logic repl);
      cp_item_type item;
      item.cp   = cp;
      item.repl = repl;
      item.last = 1'b0;
      item.done = 1'b0;
      if (decoded_count < 4) begin
         decoded_cps[decoded_count] = item;
         decoded_count++;
      end
   endfunction

   function automatic void put_replacements(int count);
      for (int i = 0; i < count; i++) put_cp(REPLACEMENT_CP, 1'b1);
   endfunction

   function automatic void clear_seq();
      scalar_acc = '0;
      seq_len    = SEQ_NONE;
      seq_taken  = '0;
   endfunction

   function automatic void expect_cp(cp_item_type item);
      pending_cps[pend_wr] = item;
      pend_wr++;
   endfunction

   function automatic void decode_byte(logic [7:0] b, logic eot);
      logic [CP_W-1:0] v;
      logic [CP_W-1:0] floor_cp;
      logic [2:0]      g;
      bit              taken;
      taken = 0;
      decoded_count = 0;
      if (seq_len != SEQ_NONE) begin
         if (b[7:6] == 2'b10) begin
            v     = {scalar_acc[14:0], b[5:0]};
            g     = {1'b0, seq_taken} + 3'd1;
            taken = 1;
            if (g >= seq_len) begin
               floor_cp = (seq_len == SEQ_TWO) ? MIN_TWO :
                          (seq_len == SEQ_THREE) ? MIN_THREE : MIN_FOUR;
               if (v < floor_cp || v > MAX_SCALAR || (v >= SURR_LOW && v <= SURR_HIGH))
                  put_replacements(int'(seq_len));
               else
                  put_cp(v, 1'b0);
               clear_seq();
            end else begin
               scalar_acc = v;
               seq_taken  = g[1:0];
            end
         end else begin
            put_replacements(int'(seq_taken));
            clear_seq();
         end
      end
      if (!taken) begin
         casez (b)
            8'b0???????: put_cp({13'b0, b}, 1'b0);
            8'b110?????: begin
               scalar_acc = {16'b0, b[4:0]};
               seq_len    = SEQ_TWO;
               seq_taken  = 2'd1;
            end
            8'b1110????: begin
               scalar_acc = {17'b0, b[3:0]};
               seq_len    = SEQ_THREE;
               seq_taken  = 2'd1;
            end
            8'b11110???: begin
               scalar_acc = {18'b0, b[2:0]};
               seq_len    = SEQ_FOUR;
               seq_taken  = 2'd1;
            end
            default: put_cp(REPLACEMENT_CP, 1'b1);
         endcase
      end
      if (eot && seq_len != SEQ_NONE) begin
         put_replacements(int'(seq_taken));
         clear_seq();
      end
      if (decoded_count > 0) begin
         decoded_cps[decoded_count - 1].last = 1'b1;
         decoded_cps[decoded_count - 1].done = eot;
      end
   endfunction

   function automatic void add_byte(logic [7:0] b);
      text_bytes[text_count] = b;
      text_ends[text_count]  = ($urandom_range(24) == 0);
      text_count++;
   endfunction

   function automatic void add_seq(logic [CP_W-1:0] v, int len, int keep);
      logic [7:0] enc [4];
      case (len)
         1: enc[0] = v[7:0];
         2: begin
            enc[0] = {3'b110, v[10:6]};
            enc[1] = {2'b10, v[5:0]};
         end
         3: begin
            enc[0] = {4'b1110, v[15:12]};
            enc[1] = {2'b10, v[11:6]};
            enc[2] = {2'b10, v[5:0]};
         end
         default: begin
            enc[0] = {5'b11110, v[20:18]};
            enc[1] = {2'b10, v[17:12]};
            enc[2] = {2'b10, v[11:6]};
            enc[3] = {2'b10, v[5:0]};
         end
      endcase
      for (int i = 0; i < keep; i++) add_byte(enc[i]);
   endfunction

   function automatic void add_random_unit();
      int              pick;
      int              len;
      logic [CP_W-1:0] v;
      pick = $urandom_range(99);
      if (pick < 15) begin
         add_seq(CP_W'($urandom_range(0, 'h7F)), 1, 1);
      end else if (pick < 35) begin
         add_seq(CP_W'($urandom_range('h80, 'h7FF)), 2, 2);
      end else if (pick < 55) begin
         v = CP_W'($urandom_range('h800, 'hFFFF));
         if (v >= SURR_LOW && v <= SURR_HIGH) v = v ^ 21'h002000;
         add_seq(v, 3, 3);
      end else if (pick < 75) begin
         add_seq(CP_W'($urandom_range('h10000, 'h10FFFF)), 4, 4);
      end else if (pick < 80) begin
         len = $urandom_range(2, 4);
         v   = (len == 2) ? CP_W'($urandom_range(0, 'h7F)) :
               (len == 3) ? CP_W'($urandom_range(0, 'h7FF)) :
                            CP_W'($urandom_range(0, 'hFFFF));
         add_seq(v, len, len);
      end else if (pick < 84) begin
         add_seq(CP_W'($urandom_range('hD800, 'hDFFF)), 3, 3);
      end else if (pick < 88) begin
         add_seq(CP_W'($urandom_range('h110000, 'h1FFFFF)), 4, 4);
      end else if (pick < 94) begin
         len = $urandom_range(2, 4);
         add_seq(CP_W'($urandom_range(0, 'h1FFFFF)), len, $urandom_range(1, len - 1));
      end else if (pick < 97) begin
         repeat ($urandom_range(1, 2)) add_byte(8'($urandom_range('h80, 'hBF)));
      end else begin
         add_byte($urandom_range(0, 1) ? 8'($urandom_range('hF8, 'hFF))
                                       : 8'($urandom_range(0, 255)));
      end
   endfunction

   task automatic send_byte(text_row_type row);
      cp_item_type item;
      @(negedge clock);
      while (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_text_byte   <= row.text_byte;
      req_end_of_text <= row.eot;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      decode_byte(row.text_byte, row.eot);
      if (row.eot) texts_closed++;
      if (row.typed) begin
         item.cp   = row.cp;
         item.repl = row.repl;
         item.last = 1'b1;
         item.done = row.eot;
         expect_cp(item);
      end else begin
         for (int i = 0; i < decoded_count; i++) expect_cp(decoded_cps[i]);
      end
   endtask

   always @(negedge clock) begin
      rsp_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
   end

   always @(posedge clock) begin
      cp_item_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pend_rd == pend_wr) begin
            error_count++;
            $display("%0t: unexpected item cp=%h repl=%b last=%b done=%b", $time,
                     rsp_code_point, rsp_is_replacement, rsp_last_of_run, rsp_text_done);
         end else begin
            want = pending_cps[pend_rd];
            pend_rd++;
            cps_checked++;
            if (want.repl) repl_checked++;
            if (rsp_code_point !== want.cp || rsp_is_replacement !== want.repl ||
                rsp_last_of_run !== want.last || rsp_text_done !== want.done) begin
               error_count++;
               $display("%0t: mismatch expected cp=%h repl=%b last=%b done=%b,",
                        $time, want.cp, want.repl, want.last, want.done);
               $display("   got cp=%h repl=%b last=%b done=%b", rsp_code_point,
                        rsp_is_replacement, rsp_last_of_run, rsp_text_done);
            end
         end
      end
   end

   initial begin
      text_row_type row;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_text_byte   = 8'h00;
      req_end_of_text = 1'b0;
      rsp_stall       = 1'b0;
      calm            = 0;
      error_count     = 0;
      cycle_count     = 0;
      cps_checked     = 0;
      repl_checked    = 0;
      texts_closed    = 0;
      pend_wr         = 0;
      pend_rd         = 0;
      decoded_count   = 0;
      text_count      = 0;
      clear_seq();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (text_rows[i]) send_byte(text_rows[i]);

      while (text_count < RANDOM_BYTES) add_random_unit();
      for (int i = 0; i < text_count; i++) begin
         calm          = (i >= 100 && i < 180);
         row           = '0;
         row.text_byte = text_bytes[i];
         row.eot       = text_ends[i];
         send_byte(row);
      end
      calm = 0;
      @(negedge clock);
      req_valid <= 1'b0;

      while (pend_rd != pend_wr) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("summary: %0d bytes in %0d closed texts, %0d code points checked (%0d replacements)",
               $size(text_rows) + text_count, texts_closed, cps_checked, repl_checked);
      if (error_count == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/utf8d_pkg.sv
rtl/utf8d_front.sv
rtl/utf8d_queue.sv
rtl/utf8d_back.sv
rtl/utf8_decoder_with_replacement.sv
dv/tb_top.sv
